/* sv/epwr_pkg.sv */
// ----------------------------------------------------------------------------
// epwr_pkg
// Shared types and constants for the echo pulse width ranger.
// ----------------------------------------------------------------------------
package epwr_pkg;

    // Event codes on the input channel
    localparam logic [1:0] OP_WRAP      = 2'd0;
    localparam logic [1:0] OP_EDGE      = 2'd1;
    localparam logic [1:0] OP_WRAP_EDGE = 2'd2;
    localparam logic [1:0] OP_CLEAR     = 2'd3;

    // Configuration register indexes
    localparam int          CFG_IDX_W    = 2;
    localparam logic [1:0]  CFG_VELOCITY = 2'd0;
    localparam logic [1:0]  CFG_LIMIT    = 2'd1;

    // Fixed field widths
    localparam int VEL_W      = 16;
    localparam int TICKS_W    = 24;
    localparam int DIST_W     = 23;
    localparam int DIST_SHIFT = 17;
    localparam int PROD_W     = VEL_W + TICKS_W;

    localparam logic [TICKS_W-1:0] TICKS_MAX     = 24'hFF_FFFF;
    localparam logic [VEL_W-1:0]   VELOCITY_INIT = 16'd2228;
    localparam logic [DIST_W-1:0]  LIMIT_INIT    = 23'd30;

    // Snapshot of the measurement after one event
    typedef struct packed {
        logic               done;
        logic [TICKS_W-1:0] ticks;
        logic               back_left;
    } meas_t;

endpackage

/* sv/epwr_meas.sv */
// ----------------------------------------------------------------------------
// epwr_meas
// Pulse measurement state: arm on the rising edge, count wraps, finish on
// the falling edge or on wrap saturation, and publish the updated snapshot.
// ----------------------------------------------------------------------------
module epwr_meas
    import epwr_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int WRAP_BITS  = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [1:0]            opcode,
    input  logic [COUNT_BITS-1:0] captured_count,
    output meas_t                 meas
);

    localparam int FULL_W = WRAP_BITS + COUNT_BITS;
    localparam int EXT_W  = (FULL_W > TICKS_W) ? FULL_W : TICKS_W;

    logic                  done_reg,    done_next;
    logic                  high_reg,    high_next;
    logic [WRAP_BITS-1:0]  wrap_reg,    wrap_next;
    logic [COUNT_BITS-1:0] latched_reg, latched_next;

    logic                  wrap_ev;
    logic                  edge_ev;
    logic [EXT_W-1:0]      ticks_ext;

    // Decode the event into its wrap and edge parts
    always_comb
    begin
        wrap_ev = 1'b0;
        edge_ev = 1'b0;
        unique case (opcode)
            OP_WRAP:
            begin
                wrap_ev = 1'b1;
            end
            OP_EDGE:
            begin
                edge_ev = 1'b1;
            end
            OP_WRAP_EDGE:
            begin
                wrap_ev = 1'b1;
                edge_ev = 1'b1;
            end
            default:
            begin
                wrap_ev = 1'b0;
                edge_ev = 1'b0;
            end
        endcase
    end

    // Apply the wrap first, then the edge; freeze once done until a clear
    always_comb
    begin
        done_next    = done_reg;
        high_next    = high_reg;
        wrap_next    = wrap_reg;
        latched_next = latched_reg;
        if (opcode == OP_CLEAR)
        begin
            done_next    = 1'b0;
            high_next    = 1'b0;
            wrap_next    = '0;
            latched_next = '0;
        end
        else if (!done_reg)
        begin
            if (wrap_ev && high_reg)
            begin
                if (wrap_reg == {WRAP_BITS{1'b1}})
                begin
                    done_next    = 1'b1;
                    latched_next = {COUNT_BITS{1'b1}};
                end
                else
                begin
                    wrap_next = wrap_reg + 1'b1;
                end
            end
            if (edge_ev)
            begin
                if (!high_reg)
                begin
                    done_next    = 1'b0;
                    high_next    = 1'b1;
                    wrap_next    = '0;
                    latched_next = '0;
                end
                else
                begin
                    done_next    = 1'b1;
                    latched_next = captured_count;
                end
            end
        end
    end

    // Hold state between transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            high_reg    <= 1'b0;
            wrap_reg    <= '0;
            latched_reg <= '0;
        end
        else if (fire)
        begin
            done_reg    <= done_next;
            high_reg    <= high_next;
            wrap_reg    <= wrap_next;
            latched_reg <= latched_next;
        end
    end

    // Build the saturated tick total from the updated state
    assign ticks_ext = EXT_W'({wrap_next, latched_next});

    always_comb
    begin
        meas.done      = done_next;
        meas.back_left = wrap_next[0];
        if (ticks_ext > EXT_W'(TICKS_MAX))
        begin
            meas.ticks = TICKS_MAX;
        end
        else
        begin
            meas.ticks = ticks_ext[TICKS_W-1:0];
        end
    end

`ifndef ASSERT_OFF
    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && opcode == OP_CLEAR) |=>
            (!done_reg && !high_reg && wrap_reg == '0 && latched_reg == '0))
        else $error("clear did not reset the measurement");

    a_done_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && done_reg && opcode != OP_CLEAR) |=>
            (done_reg && $stable(wrap_reg) && $stable(latched_reg)))
        else $error("measurement changed after completion");

    a_wrap_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        (!high_reg) |-> (wrap_reg == '0 && !done_reg))
        else $error("wraps counted or done set without a rising edge");
`endif

endmodule

/* sv/echo_pulse_width_ranger.sv */
// ----------------------------------------------------------------------------
// echo_pulse_width_ranger
// Echo pulse width measurement from timer events, with distance scaling
// and an obstacle flag.
// ----------------------------------------------------------------------------
// Pipeline: input transfer to result valid through registered stages (state update,
// multiply, limit compare), each stage a register.
// Throughput: one event per cycle while the output is not stalled; the velocity multiplier is the widest path.
// Reset: rst_n clears the measurement and pipeline valids, and loads the
// velocity (2228) and limit (30) registers.
module echo_pulse_width_ranger
    import epwr_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int WRAP_BITS  = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [COUNT_BITS-1:0] captured_count,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  measure_done,
    output logic [TICKS_W-1:0]    pulse_ticks,
    output logic [DIST_W-1:0]     distance,
    output logic                  too_close,
    output logic                  back_left,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DIST_W-1:0]     cfg_data
);

    logic               in_fire;
    meas_t              meas;

    logic [VEL_W-1:0]   velocity_reg;
    logic [DIST_W-1:0]  limit_reg;

    logic               s1_valid_reg;
    meas_t              s1_reg;
    logic               s1_ready;

    logic               s2_valid_reg;
    meas_t              s2_reg;
    logic [DIST_W-1:0]  s2_dist_reg;
    logic               s2_ready;
    logic [PROD_W-1:0]  product;

    logic               out_stage_ready;
    logic               done_reg;
    logic [TICKS_W-1:0] ticks_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               close_reg;
    logic               left_reg;

    // Per-stage ready so empty stages keep filling while the output stalls
    assign out_stage_ready = !out_valid || out_ready;
    assign s2_ready        = !s2_valid_reg || out_stage_ready;
    assign s1_ready        = !s1_valid_reg || s2_ready;
    assign in_ready        = s1_ready;
    assign in_fire         = in_valid && in_ready;

    // Measurement state
    epwr_meas #(
        .COUNT_BITS (COUNT_BITS),
        .WRAP_BITS  (WRAP_BITS)
    ) u_meas (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (in_fire),
        .opcode         (opcode),
        .captured_count (captured_count),
        .meas           (meas)
    );

    // Configuration writes; indexes beyond the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_reg <= VELOCITY_INIT;
            limit_reg    <= LIMIT_INIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_VELOCITY: velocity_reg <= cfg_data[VEL_W-1:0];
                CFG_LIMIT:    limit_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Stage 1: capture the updated snapshot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg <= meas;
        end
    end

    // Stage 2: scale ticks by velocity, drop the round-trip bit and fraction
    assign product = PROD_W'(s1_reg.ticks) * PROD_W'(velocity_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg      <= s1_reg;
            s2_dist_reg <= product[DIST_SHIFT +: DIST_W];
        end
    end

    // Stage 3: compare against the limit and hold the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (out_stage_ready)
        begin
            out_valid <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_stage_ready && s2_valid_reg)
        begin
            done_reg  <= s2_reg.done;
            ticks_reg <= s2_reg.ticks;
            dist_reg  <= s2_dist_reg;
            close_reg <= s2_reg.done && (s2_dist_reg <= limit_reg);
            left_reg  <= s2_reg.back_left;
        end
    end

    assign measure_done = done_reg;
    assign pulse_ticks  = ticks_reg;
    assign distance     = dist_reg;
    assign too_close    = close_reg;
    assign back_left    = left_reg;

`ifndef ASSERT_OFF
    a_close_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!too_close || measure_done))
        else $error("obstacle reported before the measurement completed");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && out_valid && !out_ready))
        else $error("input stalled while the pipeline had room");

    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> s2_valid_reg)
        else $error("stage 1 item lost on its way to stage 2");
`endif

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for echo_pulse_width_ranger. Timer events go in over a
// valid/ready channel with bursty timing, and the results come back through a
// receiver that stalls on its own pattern. An in-bench model of the
// measurement predicts every result. The run covers directed event
// sequences, wrap-count saturation, a long output stall that backs up the
// input, and random pulses under several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import epwr_pkg::*;

    localparam int COUNT_BITS   = 16;
    localparam int WRAP_BITS    = 8;
    localparam int HALF_PERIOD  = 5;
    localparam int RANDOM_ITEMS = 160;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int REPORT_MAX   = 10;

    // Register indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_e;

    // One result as the block reports it
    typedef struct packed {
        logic               done;
        logic [TICKS_W-1:0] ticks;
        logic [DIST_W-1:0]  reach;
        logic               close;
        logic               left;
    } reading_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             opcode;
    logic [COUNT_BITS-1:0]  captured_count;
    logic                   out_valid;
    logic                   out_ready;
    logic                   measure_done;
    logic [TICKS_W-1:0]     pulse_ticks;
    logic [DIST_W-1:0]      distance;
    logic                   too_close;
    logic                   back_left;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DIST_W-1:0]      cfg_data;

    // Predicted measurement state and registers
    logic                   meas_done;
    logic                   meas_armed;
    logic [WRAP_BITS-1:0]   meas_wraps;
    logic [COUNT_BITS-1:0]  meas_latch;
    logic [VEL_W-1:0]       reg_velocity;
    logic [DIST_W-1:0]      reg_limit;

    reading_t               pending_readings[$];
    reading_t               got;
    reading_t               want;

    int mismatches      = 0;
    int results_checked = 0;
    int events_sent     = 0;
    int effective_events = 0;
    int pulses_done     = 0;
    int close_reports   = 0;
    int reg_writes      = 0;
    int input_stalls    = 0;
    int cycle_count     = 0;
    int burst_left      = 0;
    bit sender_bursty   = 1'b1;
    bit hold_request    = 1'b0;

    echo_pulse_width_ranger #(
        .COUNT_BITS (COUNT_BITS),
        .WRAP_BITS  (WRAP_BITS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .captured_count (captured_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .measure_done   (measure_done),
        .pulse_ticks    (pulse_ticks),
        .distance       (distance),
        .too_close      (too_close),
        .back_left      (back_left),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Free-running clock
    always #HALF_PERIOD clk = ~clk;

    // Drop the measurement back to its idle state
    function automatic void clear_measurement();
        meas_done  = 1'b0;
        meas_armed = 1'b0;
        meas_wraps = '0;
        meas_latch = '0;
    endfunction

    // Apply one timer event to the predicted state and return the result
    function automatic reading_t measure_event(logic [1:0] op, logic [COUNT_BITS-1:0] cap);
        reading_t             r;
        logic [PROD_W-1:0]    prod;
        logic [TICKS_W+1:0]   prior;
        logic                 was_done;
        logic                 wrap_ev;
        logic                 edge_ev;
        prior    = {meas_done, meas_armed, meas_wraps, meas_latch};
        was_done = meas_done;
        wrap_ev  = (op == OP_WRAP) || (op == OP_WRAP_EDGE);
        edge_ev  = (op == OP_EDGE) || (op == OP_WRAP_EDGE);
        if (op == OP_CLEAR)
            clear_measurement();
        else if (!meas_done)
        begin
            // wraps only count once the rising edge has armed the measurement
            if (wrap_ev && meas_armed)
            begin
                if (meas_wraps == '1)
                begin
                    meas_done  = 1'b1;
                    meas_latch = '1;
                end
                else
                    meas_wraps = meas_wraps + 1'b1;
            end
            // the edge is still taken after a saturating wrap in the same event
            if (edge_ev)
            begin
                if (!meas_armed)
                begin
                    clear_measurement();
                    meas_armed = 1'b1;
                end
                else
                begin
                    meas_done  = 1'b1;
                    meas_latch = cap;
                end
            end
        end
        if (prior != {meas_done, meas_armed, meas_wraps, meas_latch})
            effective_events++;
        if (meas_done && !was_done)
            pulses_done++;

        // wraps and count fill exactly 24 bits, so the total cannot overflow
        r.done  = meas_done;
        r.ticks = {meas_wraps, meas_latch};
        prod    = PROD_W'(r.ticks) * PROD_W'(reg_velocity);
        r.reach = prod[DIST_SHIFT +: DIST_W];
        r.close = meas_done && (r.reach <= reg_limit);
        r.left  = meas_wraps[0];
        return r;
    endfunction

    // Capture values weighted toward the extremes
    function automatic logic [COUNT_BITS-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        return COUNT_BITS'($urandom());
    endfunction

    function automatic logic [1:0] pick_op(bit with_clear);
        case ($urandom_range(0, with_clear ? 3 : 2))
            0:       return OP_WRAP;
            1:       return OP_EDGE;
            2:       return OP_WRAP_EDGE;
            default: return OP_CLEAR;
        endcase
    endfunction

    // Offer one event and hold it until transfer; gaps fall between bursts
    task automatic send_event(input logic [1:0] op, input logic [COUNT_BITS-1:0] cap);
        int gap;
        if (sender_bursty)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
            burst_left--;
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        opcode         <= op;
        captured_count <= cap;
        @(posedge clk);
        while (!in_ready)
        begin
            input_stalls++;
            @(posedge clk);
        end
        pending_readings.push_back(measure_event(op, cap));
        events_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_VELOCITY)
            reg_velocity = data[VEL_W-1:0];
        else if (idx == CFG_LIMIT)
            reg_limit = data;
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Reset registers, early wraps, a full pulse, ignored events, clears
    task automatic test_directed_events();
        send_event(OP_WRAP, 16'h1234);
        send_event(OP_EDGE, '0);
        send_event(OP_WRAP, '0);
        send_event(OP_WRAP, '1);
        send_event(OP_EDGE, '1);
        send_event(OP_WRAP, '0);
        send_event(OP_EDGE, 16'h00FF);
        send_event(OP_WRAP_EDGE, 16'h0F0F);
        send_event(OP_CLEAR, '1);
        send_event(OP_EDGE, 16'h8000);
        send_event(OP_EDGE, 16'h0001);
        send_event(OP_CLEAR, '0);
        send_event(OP_WRAP_EDGE, 16'h5555);
        send_event(OP_WRAP_EDGE, 16'hAAAA);
        send_event(OP_CLEAR, 16'h7FFF);
        send_event(OP_CLEAR, '0);
        send_event(OP_WRAP_EDGE, '0);
        send_event(OP_CLEAR, '0);
    endtask

    // Run the wrap count into its ceiling, alone and together with an edge
    task automatic test_wrap_saturation();
        int i;
        wait_idle();
        write_reg(CFG_VELOCITY, {7'h55, 16'hFFFF});
        write_reg(CFG_LIMIT, 23'h7F_0000);
        send_event(OP_EDGE, pick_count());
        for (i = 0; i < (1 << WRAP_BITS); i++)
            send_event(OP_WRAP, pick_count());
        send_event(OP_WRAP, pick_count());
        send_event(OP_CLEAR, pick_count());
        send_event(OP_EDGE, pick_count());
        for (i = 0; i < (1 << WRAP_BITS) - 1; i++)
            send_event(OP_WRAP, pick_count());
        send_event(OP_WRAP_EDGE, 16'h0123);
        send_event(OP_EDGE, pick_count());
        send_event(OP_CLEAR, pick_count());
    endtask

    // Hold the receiver off while events keep coming, so the input stalls
    task automatic test_output_stall();
        int i;
        wait_idle();
        sender_bursty = 1'b0;
        hold_request  = 1'b1;
        send_event(OP_CLEAR, pick_count());
        send_event(OP_EDGE, pick_count());
        for (i = 0; i < 45; i++)
            send_event(OP_WRAP, pick_count());
        send_event(OP_EDGE, pick_count());
        sender_bursty = 1'b1;
    endtask

    // Mostly well-formed pulses with random content, plus noise
    task automatic test_random_pulses();
        int phase;
        int start;
        int wraps;
        int extra;
        int i;
        for (phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    write_reg(CFG_VELOCITY, DIST_W'(VELOCITY_INIT));
                    write_reg(CFG_LIMIT, LIMIT_INIT);
                end
                1:
                begin
                    write_reg(CFG_VELOCITY, '0);
                    write_reg(CFG_LIMIT, '0);
                end
                2:
                begin
                    write_reg(CFG_VELOCITY, '1);
                    write_reg(CFG_LIMIT, '1);
                end
                default:
                begin
                    write_reg(CFG_VELOCITY, DIST_W'($urandom()));
                    write_reg(CFG_LIMIT, DIST_W'($urandom_range(0, 3000)));
                    write_reg(CFG_SPARE_2, DIST_W'($urandom()));
                    write_reg(CFG_SPARE_3, DIST_W'($urandom()));
                end
            endcase
            start = events_sent;
            while (events_sent - start < RANDOM_ITEMS / 4)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    if (meas_done || meas_armed)
                        send_event(OP_CLEAR, pick_count());
                    send_event($urandom_range(0, 1) ? OP_EDGE : OP_WRAP_EDGE, pick_count());
                    wraps = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 5)
                                                         : $urandom_range(6, 60);
                    for (i = 0; i < wraps; i++)
                        send_event(OP_WRAP, pick_count());
                    send_event($urandom_range(0, 1) ? OP_EDGE : OP_WRAP_EDGE, pick_count());
                    extra = $urandom_range(0, 2);
                    for (i = 0; i < extra; i++)
                        send_event(pick_op(1'b0), pick_count());
                end
                else
                begin
                    extra = $urandom_range(1, 4);
                    for (i = 0; i < extra; i++)
                        send_event(pick_op(1'b1), pick_count());
                end
            end
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display({"MISMATCH %s at cycle %0d: expected done=%0d ticks=%h dist=%h ",
                      "close=%0d left=%0d, got done=%0d ticks=%h dist=%h close=%0d left=%0d"},
                     what, cycle_count, want.done, want.ticks, want.reach, want.close,
                     want.left, got.done, got.ticks, got.reach, got.close, got.left);
    endtask

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got = '{measure_done, pulse_ticks, distance, too_close, back_left};
            if (pending_readings.size() == 0)
            begin
                want = '0;
                note_mismatch("unexpected result");
            end
            else
            begin
                want = pending_readings.pop_front();
                results_checked++;
                if (got.close === 1'b1)
                    close_reports++;
                if (got.done !== want.done || got.ticks !== want.ticks ||
                    got.reach !== want.reach || got.close !== want.close ||
                    got.left !== want.left)
                    note_mismatch("result");
            end
        end
    end

    // Receiver: switch between steady, random and periodic stalls, with holds
    initial
    begin : receiver
        rx_mode_e mode;
        int       seg_left;
        int       hold_left;
        int       tick;
        out_ready = 1'b0;
        mode      = RX_STEADY;
        seg_left  = 0;
        hold_left = 0;
        tick      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (seg_left == 0)
            begin
                mode     = rx_mode_e'($urandom_range(0, 2));
                seg_left = $urandom_range(20, 120);
            end
            seg_left--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_RANDOM:   out_ready <= ($urandom_range(0, 99) < 60);
                    RX_PERIODIC: out_ready <= ((tick % 4) != 0);
                    default:     out_ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, pending_readings.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_WRAP;
        captured_count = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_VELOCITY;
        cfg_data       = '0;
        clear_measurement();
        reg_velocity   = VELOCITY_INIT;
        reg_limit      = LIMIT_INIT;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_events();
        test_wrap_saturation();
        test_output_stall();
        test_random_pulses();
        wait_idle();

        $display("Run covered %0d events (%0d changed state), %0d results checked, %0d %s",
                 events_sent, effective_events, results_checked, reg_writes,
                 "register writes");
        $display("Completed pulses: %0d, obstacle reports: %0d, input stall cycles: %0d",
                 pulses_done, close_reports, input_stalls);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
